// ===== hw/rtl/chm_pkg.sv =====
package chm_pkg;

  // CORDIC datapath widths: x/y carry the prescaled axes plus CORDIC growth,
  // z carries angles in units of 2^-16 rad.
  localparam int unsigned XY_W       = 28;
  localparam int unsigned Z_W        = 20;
  localparam int unsigned MAX_STAGES = 24;

  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [18:0]           PI_Q16      = 19'd205887;
  localparam logic [18:0]           TWO_PI_Q16  = 19'd411775;
  localparam logic [14:0]           DEG_FULL    = 15'd23040;

  // floor(23040 * 2^32 / 411775), used to estimate the degree quotient
  localparam logic [27:0] RECIP_K = 28'((64'd23040 << 32) / 64'd411775);

  // atan(2^-i) in units of 2^-16 rad, rounded to nearest
  localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

  // configuration register indexes; REG_NONE is unmapped
  typedef enum logic [1:0] {
    REG_GAIN_X = 2'd0,
    REG_GAIN_Y = 2'd1,
    REG_DECL   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } chm_vec_t;

endpackage

// ===== hw/rtl/chm_if.sv =====
interface chm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_high;
  logic [7:0] x_low;
  logic [7:0] y_high;
  logic [7:0] y_low;

  modport source (output valid, output x_high, output x_low, output y_high,
                  output y_low, input ready);
  modport sink   (input valid, input x_high, input x_low, input y_high,
                  input y_low, output ready);
endinterface

interface chm_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

// ===== hw/rtl/chm_front.sv =====
module chm_front import chm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  logic [7:0] x_high_i,
  input  logic [7:0] x_low_i,
  input  logic [7:0] y_high_i,
  input  logic [7:0] y_low_i,
  input  logic [15:0] gain_x_i,
  input  logic [15:0] gain_y_i,
  output logic       rdy_o,
  output logic       vld_o,
  output chm_vec_t   vec_o,
  input  logic       rdy_i
);

  logic [1:0] vld_q;
  logic [2:0] adv;

  logic signed [15:0] raw_x, raw_y;
  logic signed [32:0] rx, ry, gx, gy;
  logic signed [32:0] prod_x_q, prod_y_q;
  logic signed [32:0] tx, ty;
  logic signed [16:0] sx, sy;
  logic signed [XY_W-1:0] px, py;
  chm_vec_t vec_d, vec_q;

  assign adv[2] = rdy_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign rdy_o  = adv[0];
  assign vld_o  = vld_q[1];
  assign vec_o  = vec_q;

  assign raw_x = {x_high_i, x_low_i};
  assign raw_y = {y_high_i, y_low_i};
  assign rx    = 33'(raw_x);
  assign ry    = 33'(raw_y);
  assign gx    = {17'b0, gain_x_i};
  assign gy    = {17'b0, gain_y_i};

  // divide by 2^15 truncating toward zero: bias negative products first
  assign tx = prod_x_q[32] ? prod_x_q + 33'sd32767 : prod_x_q;
  assign ty = prod_y_q[32] ? prod_y_q + 33'sd32767 : prod_y_q;
  assign sx = tx[31:15];
  assign sy = ty[31:15];
  assign px = {{(XY_W-25){sx[16]}}, sx, 8'b0};
  assign py = {{(XY_W-25){sy[16]}}, sy, 8'b0};

  always_comb begin
    vec_d.zero = (sx == 17'sd0) && (sy == 17'sd0);
    vec_d.x    = px;
    vec_d.y    = py;
    vec_d.z    = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        vec_d.x = py;
        vec_d.y = -px;
        vec_d.z = HALF_PI_Q16;
      end else begin
        vec_d.x = -py;
        vec_d.y = px;
        vec_d.z = -HALF_PI_Q16;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= vld_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prod_x_q <= rx * gx;
      prod_y_q <= ry * gy;
    end
    if (adv[1]) vec_q <= vec_d;
  end

endmodule

// ===== hw/rtl/chm_cell.sv =====
module chm_cell import chm_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     vld_i,
  input  chm_vec_t vec_i,
  output logic     rdy_o,
  output logic     vld_o,
  output chm_vec_t vec_o,
  input  logic     rdy_i
);

  logic vld_q;
  chm_vec_t vec_d, vec_q;
  logic signed [XY_W-1:0] dx, dy;

  assign rdy_o = !vld_q || rdy_i;
  assign vld_o = vld_q;
  assign vec_o = vec_q;

  assign dx = vec_i.y >>> STAGE;
  assign dy = vec_i.x >>> STAGE;

  // rotate toward y = 0, accumulate the turned angle
  always_comb begin
    vec_d.zero = vec_i.zero;
    if (!vec_i.y[XY_W-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ATAN_TAB[STAGE];
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) vec_q <= vec_d;
  end

endmodule

// ===== hw/rtl/chm_back.sv =====
module chm_back import chm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  chm_vec_t    vec_i,
  input  logic [14:0] decl_i,
  output logic        rdy_o,
  output logic        vld_o,
  output logic [14:0] heading_o,
  input  logic        rdy_i
);

  localparam logic signed [20:0] TWO_PI_S  = 21'sd411775;
  localparam logic signed [20:0] FOUR_PI_S = 21'sd823550;

  logic [4:0] vld_q;
  logic [5:0] adv;

  logic signed [20:0] z_ext, d_ext, h_d, h_q, w_d;
  logic [18:0] w_q;
  logic [47:0] pe_q;
  logic [33:0] n2_q, n3_q, m_q, rem;
  logic [14:0] est, est_q, heading_q;

  assign adv[5] = rdy_i;
  for (genvar k = 0; k < 5; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign rdy_o     = adv[0];
  assign vld_o     = vld_q[4];
  assign heading_o = heading_q;

  // add declination scaled to 2^-16 rad
  assign z_ext = vec_i.zero ? 21'sd0 : 21'(vec_i.z);
  assign d_ext = {{2{decl_i[14]}}, decl_i, 4'b0};
  assign h_d   = z_ext + d_ext;

  // wrap into 0..2pi
  always_comb begin
    if (h_q < -TWO_PI_S)      w_d = h_q + FOUR_PI_S;
    else if (h_q < 0)         w_d = h_q + TWO_PI_S;
    else if (h_q > FOUR_PI_S) w_d = h_q - FOUR_PI_S;
    else if (h_q > TWO_PI_S)  w_d = h_q - TWO_PI_S;
    else                      w_d = h_q;
  end

  // quotient estimate is the rounded quotient or one below it
  assign est = pe_q[46:32];
  assign rem = n3_q - m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= vld_i;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) h_q <= h_d;
    if (adv[1]) w_q <= w_d[18:0];
    if (adv[2]) begin
      pe_q <= 48'(w_q) * 48'(RECIP_K) + (48'd1 << 31);
      n2_q <= 34'(w_q) * 34'(DEG_FULL) + 34'(PI_Q16);
    end
    if (adv[3]) begin
      m_q   <= 34'(est) * 34'(TWO_PI_Q16);
      est_q <= est;
      n3_q  <= n2_q;
    end
    if (adv[4]) heading_q <= (rem >= 34'(TWO_PI_Q16)) ? est_q + 15'd1 : est_q;
  end

endmodule

// ===== hw/rtl/compass_heading_from_magnetometer_top.sv =====
// Compass heading from one magnetometer sample.
// Input channel smp_i carries one item per sample: the high and low bytes of
// the X and Y axes. Output channel hdg_o carries one item per sample: the
// heading in 1/64 degree, 0 to 23040, declination included.
// Configuration: write gain_x (index 0), gain_y (index 1) and declination
// (index 2) through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle;
// other indexes are dropped.
// From accept to result valid, an item passes the scaling and quadrant fold
// registers, one CORDIC cell per angle stage, and the declination add, wrap
// and degree conversion registers. Throughput: one item per cycle while
// hdg_o is ready; every stage is a registered cell that takes a new item
// whenever it is empty or its contents move on.
// When the receiver stalls, results hold in the output register and items
// keep entering until the pipeline is full; ready then drops stage by stage.
// Reset empties every stage and loads the default gains and declination.
module compass_heading_from_magnetometer_top import chm_pkg::*; #(
  parameter int unsigned ANGLE_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chm_in_if.sink      smp_i,
  chm_out_if.source   hdg_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] gain_x_q, gain_y_q;
  logic [14:0] decl_q;

  // handshake and data along the cell row; index k feeds cell k
  logic     vld [ANGLE_STAGES+1];
  logic     rdy [ANGLE_STAGES+1];
  chm_vec_t vec [ANGLE_STAGES+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q <= 16'd30147;
      gain_y_q <= 16'd30147;
      decl_q   <= 15'h7D6B;  // -661
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_X: gain_x_q <= cfg_data_i;
        REG_GAIN_Y: gain_y_q <= cfg_data_i;
        REG_DECL:   decl_q   <= cfg_data_i[14:0];
        default:    ;  // unmapped index: drop the write
      endcase
    end
  end

  // scale both axes and fold the left half plane
  chm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (smp_i.valid),
    .x_high_i (smp_i.x_high),
    .x_low_i  (smp_i.x_low),
    .y_high_i (smp_i.y_high),
    .y_low_i  (smp_i.y_low),
    .gain_x_i (gain_x_q),
    .gain_y_i (gain_y_q),
    .rdy_o    (smp_i.ready),
    .vld_o    (vld[0]),
    .vec_o    (vec[0]),
    .rdy_i    (rdy[0])
  );

  // one vectoring cell per angle stage
  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
    chm_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[k]),
      .vec_i  (vec[k]),
      .rdy_o  (rdy[k]),
      .vld_o  (vld[k+1]),
      .vec_o  (vec[k+1]),
      .rdy_i  (rdy[k+1])
    );
  end

  // declination, wrap and conversion to 1/64 degree
  chm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (vld[ANGLE_STAGES]),
    .vec_i     (vec[ANGLE_STAGES]),
    .decl_i    (decl_q),
    .rdy_o     (rdy[ANGLE_STAGES]),
    .vld_o     (hdg_o.valid),
    .heading_o (hdg_o.heading),
    .rdy_i     (hdg_o.ready)
  );

endmodule
